// ===== hdl/scdc_pkg.sv =====
// shared constants, codes and helpers for the strip charge-division calibrator
`default_nettype none
package scdc_pkg;

  localparam int CMD_W   = 2;
  localparam int DET_W   = 8;
  localparam int SIDE_W  = 2;
  localparam int STRIP_W = 6;
  localparam int VAL_W   = 32;
  localparam int CIDX_W  = 5;
  localparam int ST_W    = 2;
  localparam int CFG_W   = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENERGY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PAIR   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_CHANNEL = 2'd1;
  localparam logic [ST_W-1:0] ST_SUM     = 2'd2;
  localparam logic [ST_W-1:0] ST_SCALE   = 2'd3;

  localparam logic [CFG_W-1:0] REG_LOWER_GATE = 2'd0;
  localparam logic [CFG_W-1:0] REG_UPPER_GATE = 2'd1;
  localparam logic [CFG_W-1:0] REG_POS_CORR   = 2'd2;

  localparam int NCOEF      = 17;
  localparam int K_C0_INT   = 0;
  localparam int K_C0_SLOPE = 1;
  localparam int K_L_INT    = 2;
  localparam int K_L_SLOPE  = 3;
  localparam int K_R_INT    = 4;
  localparam int K_R_SLOPE  = 5;
  localparam int K_P0       = 6;
  localparam int K_P1       = 7;
  localparam int K_P2       = 8;
  localparam int K_C3_INT   = 9;
  localparam int K_C3_SLOPE = 10;
  localparam int K_X01      = 11;
  localparam int K_X11      = 14;

  // quotient bits resolved per divider stage
  localparam int DIV_BPS   = 4;
  localparam int DIV_STEPS = 32 / DIV_BPS;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/scdc_if.sv =====
// valid/ready channel interfaces for hits, results and register writes
`default_nettype none
interface scdc_hit_if;
  logic                                valid;
  logic                                ready;
  logic [scdc_pkg::CMD_W-1:0]          command;
  logic [scdc_pkg::DET_W-1:0]          detector_index;
  logic [scdc_pkg::SIDE_W-1:0]         side_index;
  logic [scdc_pkg::STRIP_W-1:0]        strip_index;
  logic signed [scdc_pkg::VAL_W-1:0]   energy_left;
  logic signed [scdc_pkg::VAL_W-1:0]   energy_right;
  logic                                skip_position;
  logic [scdc_pkg::CIDX_W-1:0]         coefficient_index;
  logic signed [scdc_pkg::VAL_W-1:0]   coefficient_value;

  modport source (output valid, command, detector_index, side_index, strip_index,
                  energy_left, energy_right, skip_position, coefficient_index,
                  coefficient_value, input ready);
  modport sink (input valid, command, detector_index, side_index, strip_index,
                energy_left, energy_right, skip_position, coefficient_index,
                coefficient_value, output ready);
endinterface

interface scdc_result_if;
  logic                                valid;
  logic                                ready;
  logic [scdc_pkg::ST_W-1:0]           status;
  logic signed [scdc_pkg::VAL_W-1:0]   energy_out;
  logic signed [scdc_pkg::VAL_W-1:0]   position_out;

  modport source (output valid, status, energy_out, position_out, input ready);
  modport sink (input valid, status, energy_out, position_out, output ready);
endinterface

interface scdc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scdc_pkg::CFG_W-1:0]    index;
  logic [scdc_pkg::VAL_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/scdc_div.sv =====
// pipelined signed fixed-point divider, truncating and saturating to 32 bits
`default_nettype none
module scdc_div #(
  parameter int NW = 33,
  parameter int DW = 33,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [31:0]   quo
);
  import scdc_pkg::*;

  localparam int MW = NW + FB;
  localparam int CW = (MW - 32 > DW) ? MW - 32 : DW;

  typedef struct packed {
    logic neg;
    logic zero;
    logic nneg;
    logic ovf;
  } dflag_t;

  logic [NW-1:0] nabs;
  logic [DW-1:0] dabs;
  logic [MW-1:0] mag;

  logic [DW-1:0] rem  [DIV_STEPS+1];
  logic [31:0]   lo   [DIV_STEPS+1];
  logic [31:0]   qq   [DIV_STEPS+1];
  logic [DW-1:0] dm   [DIV_STEPS+1];
  dflag_t        fl   [DIV_STEPS+1];

  assign nabs = num[NW-1] ? NW'(-num) : NW'(num);
  assign dabs = den[DW-1] ? DW'(-den) : DW'(den);
  assign mag  = {nabs, {FB{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]     <= DW'(mag[MW-1:32]);
      lo[0]      <= mag[31:0];
      qq[0]      <= '0;
      dm[0]      <= dabs;
      fl[0].neg  <= num[NW-1] ^ den[DW-1];
      fl[0].zero <= (den == '0);
      fl[0].nneg <= ~num[NW-1];
      // quotient magnitude of 2^32 or more
      fl[0].ovf  <= CW'(mag[MW-1:32]) >= CW'(dabs);
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [DW-1:0] nrem;
    logic [31:0]   nlo;
    logic [31:0]   nq;

    always_comb begin
      logic [DW:0] t;
      nrem = rem[j];
      nlo  = lo[j];
      nq   = qq[j];
      for (int b = 0; b < DIV_BPS; b++) begin
        t   = {nrem, nlo[31]};
        nlo = {nlo[30:0], 1'b0};
        if (t >= {1'b0, dm[j]}) begin
          t  = t - {1'b0, dm[j]};
          nq = {nq[30:0], 1'b1};
        end else begin
          nq = {nq[30:0], 1'b0};
        end
        nrem = t[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= nrem;
        lo[j+1]  <= nlo;
        qq[j+1]  <= nq;
        dm[j+1]  <= dm[j];
        fl[j+1]  <= fl[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl[DIV_STEPS].zero) begin
        quo <= fl[DIV_STEPS].nneg ? 32'sh7fffffff : 32'sh80000000;
      end else if (fl[DIV_STEPS].ovf) begin
        quo <= fl[DIV_STEPS].neg ? 32'sh80000000 : 32'sh7fffffff;
      end else if (!fl[DIV_STEPS].neg) begin
        quo <= qq[DIV_STEPS][31] ? 32'sh7fffffff : $signed(qq[DIV_STEPS]);
      end else begin
        quo <= (qq[DIV_STEPS] > 32'h80000000) ? 32'sh80000000 : $signed(-qq[DIV_STEPS]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/strip_charge_division_calibrator_top.sv =====
// top level: coefficient tables, calibration pipeline and register port
//
// Hits enter on the hit channel and leave, one result per hit, on the result
// channel, both valid/ready. Command 0 writes one of 17 coefficients of a
// channel, command 1 calibrates a single energy, command 2 calibrates a
// left/right pair and derives the charge-division position.
// Registers (lower gate, upper gate, position-correction enable) are written
// on the cfg channel, which is always ready; write them only while no hit is
// in flight.
// A new hit is taken every cycle unless the result register is stalled or the
// reset sweep runs. The depth comes from the three ranks of 10-stage
// dividers (4 quotient bits per stage) and the multiplier stages between them.
// The whole pipeline advances together: when the result register holds an
// untaken result the pipeline freezes and the hit channel drops ready, so no
// item is lost or repeated.
// After reset the coefficient memories are swept one channel per cycle over all
// DETECTORS*SIDES*STRIPS channels, loading identity calibration; hits are not
// accepted during the sweep. A coefficient write takes effect for the very
// next hit.
`default_nettype none
module strip_charge_division_calibrator_top #(
  parameter int DETECTORS     = 16,
  parameter int SIDES         = 2,
  parameter int STRIPS        = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  scdc_hit_if.sink      hit,
  scdc_result_if.source result,
  scdc_cfg_if.sink      cfg
);
  import scdc_pkg::*;

  localparam int CHANNELS = DETECTORS * SIDES * STRIPS;
  localparam int CHW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [31:0] ONE    = 32'sd1 <<< FRACTION_BITS;
  localparam logic signed [31:0] HALF32 = 32'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [64:0] HALF65 = 65'sd1 <<< (FRACTION_BITS - 1);

  typedef struct packed {
    logic               isc1;
    logic               isc2;
    logic               full;
    logic               apply;
    logic [ST_W-1:0]    st;
    logic signed [31:0] re;
    logic signed [31:0] rp;
    logic signed [31:0] c0;
    logic signed [31:0] c2;
    logic signed [31:0] c4;
    logic signed [31:0] c6;
    logic signed [31:0] c7;
    logic signed [31:0] c8;
    logic signed [31:0] c9;
    logic signed [31:0] c10;
    logic signed [31:0] lo0;
    logic signed [31:0] lo1;
    logic signed [31:0] lo2;
    logic signed [31:0] hi0;
    logic signed [31:0] hi1;
    logic signed [31:0] hi2;
    logic signed [31:0] l;
    logic signed [31:0] r;
    logic signed [31:0] sum;
    logic signed [31:0] pos;
    logic signed [31:0] q0;
    logic signed [31:0] q1;
    logic signed [31:0] q2;
    logic signed [31:0] t7;
    logic signed [31:0] t8;
    logic signed [31:0] t88;
    logic signed [31:0] scale;
    logic signed [31:0] energy;
    logic signed [31:0] de;
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] d;
    logic signed [31:0] hnum;
    logic signed [32:0] diff;
    logic signed [32:0] dh0;
    logic signed [32:0] dh1;
    logic signed [32:0] dh2;
    logic signed [32:0] hden;
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
  } ctx_t;

  function automatic logic signed [31:0] rnd(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = 65'(p) + HALF65;
    return sat32(66'(t >>> FRACTION_BITS));
  endfunction

  // registers
  logic signed [31:0] lower_gate;
  logic signed [31:0] upper_gate;
  logic               pos_corr;
  logic signed [32:0] gate_gap;

  // reset sweep
  logic           clearing;
  logic [CHW-1:0] clr_cnt;

  // handshake
  logic en;
  logic take;
  logic chan_ok;
  logic wr_en;
  logic [CHW-1:0] addr;

  // stage registers
  logic               va;
  logic [CMD_W-1:0]   a_cmd;
  logic               a_ok;
  logic signed [31:0] a_el;
  logic signed [31:0] a_er;
  logic               a_skip;
  logic signed [31:0] rd [NCOEF];

  logic vb, vc, vd, ve, vf, vg, vh, vi, vj, vk, vl, vm, vn, vo, vp, vq, vr;
  ctx_t sb, sc, sd, se, sf, sg, sh, si, sj, sk, sl, sm, sn, so, sp, sq, sr;
  ctx_t sb_next, sc_next, sd_next, se_next, sf_next, sg_next, sh_next, si_next;
  ctx_t sj_next, sk_next, sl_next, sm_next, sn_next, so_next, sp_next, sq_next;
  ctx_t sr_next;
  ctx_t dl1 [DIV_LAT];
  ctx_t dl2 [DIV_LAT];
  ctx_t dl3 [DIV_LAT];
  logic dv1 [DIV_LAT];
  logic dv2 [DIV_LAT];
  logic dv3 [DIV_LAT];

  logic signed [31:0] q_pos, q_g0, q_g1, q_g2, q_e, q_h;
  logic signed [31:0] sum_c;
  logic signed [31:0] scale_c;
  logic               gt_c;
  logic signed [31:0] corr_c;

  logic               out_v;
  logic [ST_W-1:0]    out_st;
  logic signed [31:0] out_e;
  logic signed [31:0] out_p;

  assign en        = ~out_v | result.ready;
  assign hit.ready = en & ~clearing;
  assign take      = hit.valid & hit.ready;
  assign cfg.ready = 1'b1;
  assign gate_gap  = 33'(upper_gate) - 33'(lower_gate);

  assign chan_ok = (9'(hit.detector_index) < 9'(DETECTORS)) &&
                   (3'(hit.side_index) < 3'(SIDES)) &&
                   (7'(hit.strip_index) < 7'(STRIPS));
  assign addr  = chan_ok ? CHW'((int'(hit.detector_index) * SIDES + int'(hit.side_index))
                                * STRIPS + int'(hit.strip_index)) : '0;
  assign wr_en = take && (hit.command == CMD_WRITE) && chan_ok;

  assign result.valid        = out_v;
  assign result.status       = out_st;
  assign result.energy_out   = out_e;
  assign result.position_out = out_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_gate <= '0;
      upper_gate <= ONE;
      pos_corr   <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LOWER_GATE: lower_gate <= cfg.data;
        REG_UPPER_GATE: upper_gate <= cfg.data;
        REG_POS_CORR:   pos_corr   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CHW'(CHANNELS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // one memory per coefficient so a hit reads all 17 together
  for (genvar k = 0; k < NCOEF; k++) begin : g_coef
    localparam logic [31:0] IDENT =
      (k == K_C0_SLOPE || k == K_L_SLOPE || k == K_R_SLOPE || k == K_P0 ||
       k == K_C3_SLOPE) ? ONE : 32'd0;
    logic [31:0] mem [CHANNELS];

    always_ff @(posedge clk) begin
      if (clearing) begin
        mem[clr_cnt] <= IDENT;
      end else if (wr_en && hit.coefficient_index == CIDX_W'(k)) begin
        mem[addr] <= hit.coefficient_value;
      end
      if (en) begin
        rd[k] <= mem[addr];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve, vf, vg, vh, vi} <= '0;
      {vj, vk, vl, vm, vn, vo, vp, vq, vr} <= '0;
      out_v <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        dv1[i] <= 1'b0;
        dv2[i] <= 1'b0;
        dv3[i] <= 1'b0;
      end
    end else if (en) begin
      va <= take;
      vb <= va;
      vc <= vb;
      vd <= vc;
      dv1[0] <= vd;
      dv2[0] <= vi;
      dv3[0] <= vq;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv1[i] <= dv1[i-1];
        dv2[i] <= dv2[i-1];
        dv3[i] <= dv3[i-1];
      end
      ve <= dv1[DIV_LAT-1];
      vf <= ve;
      vg <= vf;
      vh <= vg;
      vi <= vh;
      vj <= dv2[DIV_LAT-1];
      vk <= vj;
      vl <= vk;
      vm <= vl;
      vn <= vm;
      vo <= vn;
      vp <= vo;
      vq <= vp;
      vr <= dv3[DIV_LAT-1];
      out_v <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd  <= hit.command;
      a_ok   <= chan_ok;
      a_el   <= hit.energy_left;
      a_er   <= hit.energy_right;
      a_skip <= hit.skip_position;
    end
  end

  assign sum_c   = sat32(66'(sc.l) + 66'(sc.r));
  assign scale_c = sat32(66'(sh.c6) + 66'(sh.t7) + 66'(sh.t88));
  assign gt_c    = sp.pos > sp.b1;
  assign corr_c  = rnd(sr.p0);

  always_comb begin
    // products of the linear gains
    sb_next       = '0;
    sb_next.isc1  = (a_cmd == CMD_ENERGY) && a_ok;
    sb_next.isc2  = (a_cmd == CMD_PAIR) && a_ok;
    sb_next.apply = (a_cmd == CMD_PAIR) && a_ok && !a_skip && pos_corr;
    sb_next.st    = (a_cmd != CMD_NONE && !a_ok) ? ST_CHANNEL : ST_OK;
    sb_next.re    = (a_cmd == CMD_ENERGY && !a_ok) ? a_el : 32'sd0;
    sb_next.c0    = rd[K_C0_INT];
    sb_next.c2    = rd[K_L_INT];
    sb_next.c4    = rd[K_R_INT];
    sb_next.c6    = rd[K_P0];
    sb_next.c7    = rd[K_P1];
    sb_next.c8    = rd[K_P2];
    sb_next.c9    = rd[K_C3_INT];
    sb_next.c10   = rd[K_C3_SLOPE];
    sb_next.lo0   = rd[K_X01];
    sb_next.lo1   = rd[K_X01+1];
    sb_next.lo2   = rd[K_X01+2];
    sb_next.hi0   = rd[K_X11];
    sb_next.hi1   = rd[K_X11+1];
    sb_next.hi2   = rd[K_X11+2];
    sb_next.p0    = rd[K_C0_SLOPE] * a_el;
    sb_next.p1    = rd[K_L_SLOPE] * a_el;
    sb_next.p2    = rd[K_R_SLOPE] * a_er;

    sc_next   = sb;
    sc_next.l = sat32(66'(rnd(sb.p1)) + 66'(sb.c2));
    sc_next.r = sat32(66'(rnd(sb.p2)) + 66'(sb.c4));
    if (sb.isc1) begin
      sc_next.re = sat32(66'(rnd(sb.p0)) + 66'(sb.c0));
    end

    sd_next      = sc;
    sd_next.sum  = sum_c;
    sd_next.diff = 33'(sc.r) - 33'(sc.l);
    sd_next.dh0  = 33'(sc.hi0) - 33'(sc.lo0);
    sd_next.dh1  = 33'(sc.hi1) - 33'(sc.lo1);
    sd_next.dh2  = 33'(sc.hi2) - 33'(sc.lo2);
    sd_next.full = sc.isc2 && (sum_c > 32'sd0);
    if (sc.isc2 && sum_c <= 32'sd0) begin
      sd_next.st = ST_SUM;
    end

    // ballistic scale polynomial
    se_next     = dl1[DIV_LAT-1];
    se_next.pos = q_pos;
    se_next.q0  = q_g0;
    se_next.q1  = q_g1;
    se_next.q2  = q_g2;
    se_next.p0  = dl1[DIV_LAT-1].c7 * q_pos;
    se_next.p1  = dl1[DIV_LAT-1].c8 * q_pos;

    sf_next    = se;
    sf_next.t7 = rnd(se.p0);
    sf_next.t8 = rnd(se.p1);

    sg_next    = sf;
    sg_next.p2 = sf.t8 * sf.pos;

    sh_next     = sg;
    sh_next.t88 = rnd(sg.p2);

    si_next       = sh;
    si_next.scale = scale_c;
    if (sh.full && scale_c == 32'sd0) begin
      si_next.st   = ST_SCALE;
      si_next.re   = 32'sd0;
      si_next.rp   = sh.pos;
      si_next.full = 1'b0;
    end

    // energy scaling, linear correction and breakpoint interpolation
    sj_next    = dl2[DIV_LAT-1];
    sj_next.p0 = q_e * upper_gate;

    sk_next        = sj;
    sk_next.energy = rnd(sj.p0);

    sl_next    = sk;
    sl_next.p0 = sk.c10 * sk.energy;

    sm_next        = sl;
    sm_next.energy = sat32(66'(rnd(sl.p0)) + 66'(sl.c9));

    sn_next    = sm;
    sn_next.de = sat32(66'(sm.energy) - 66'(lower_gate));

    so_next    = sn;
    so_next.p0 = sn.q0 * sn.de;
    so_next.p1 = sn.q1 * sn.de;
    so_next.p2 = sn.q2 * sn.de;

    sp_next    = so;
    sp_next.b0 = sat32(66'(rnd(so.p0)) + 66'(so.lo0));
    sp_next.b1 = sat32(66'(rnd(so.p1)) + 66'(so.lo1));
    sp_next.b2 = sat32(66'(rnd(so.p2)) + 66'(so.lo2));

    // pick the side of the middle breakpoint
    sq_next      = sp;
    sq_next.d    = sat32(66'(sp.pos) - 66'(sp.b1));
    sq_next.hnum = gt_c ? HALF32 : -HALF32;
    sq_next.hden = gt_c ? (33'(sp.b2) - 33'(sp.b1)) : (33'(sp.b0) - 33'(sp.b1));

    sr_next    = dl3[DIV_LAT-1];
    sr_next.p0 = q_h * dl3[DIV_LAT-1].d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb <= sb_next;
      sc <= sc_next;
      sd <= sd_next;
      se <= se_next;
      sf <= sf_next;
      sg <= sg_next;
      sh <= sh_next;
      si <= si_next;
      sj <= sj_next;
      sk <= sk_next;
      sl <= sl_next;
      sm <= sm_next;
      sn <= sn_next;
      so <= so_next;
      sp <= sp_next;
      sq <= sq_next;
      sr <= sr_next;
    end
  end

  // charge-division position and the gate-interpolation slopes
  scdc_div #(.NW(33), .DW(32), .FB(FRACTION_BITS)) u_div_pos (
    .clk(clk), .en(en), .num(sd.diff), .den(sd.sum), .quo(q_pos));
  scdc_div #(.NW(33), .DW(33), .FB(FRACTION_BITS)) u_div_g0 (
    .clk(clk), .en(en), .num(sd.dh0), .den(gate_gap), .quo(q_g0));
  scdc_div #(.NW(33), .DW(33), .FB(FRACTION_BITS)) u_div_g1 (
    .clk(clk), .en(en), .num(sd.dh1), .den(gate_gap), .quo(q_g1));
  scdc_div #(.NW(33), .DW(33), .FB(FRACTION_BITS)) u_div_g2 (
    .clk(clk), .en(en), .num(sd.dh2), .den(gate_gap), .quo(q_g2));

  always_ff @(posedge clk) begin
    if (en) begin
      dl1[0] <= sd;
      dl2[0] <= si;
      dl3[0] <= sq;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl1[i] <= dl1[i-1];
        dl2[i] <= dl2[i-1];
        dl3[i] <= dl3[i-1];
      end
    end
  end

  scdc_div #(.NW(32), .DW(32), .FB(FRACTION_BITS)) u_div_e (
    .clk(clk), .en(en), .num(si.sum), .den(si.scale), .quo(q_e));

  scdc_div #(.NW(32), .DW(33), .FB(FRACTION_BITS)) u_div_h (
    .clk(clk), .en(en), .num(sq.hnum), .den(sq.hden), .quo(q_h));

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      out_st <= sr.st;
      out_e  <= sr.full ? sr.energy : sr.re;
      out_p  <= sr.full ? (sr.apply ? corr_c : sr.pos) : sr.rp;
    end
  end

`ifndef SYNTHESIS
  a_no_take_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !hit.ready)
    else $error("hit taken during coefficient sweep");

  a_freeze_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !hit.ready)
    else $error("hit taken while result register is stalled");

  a_sweep_length: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_cnt) == CHW'(CHANNELS - 1))
    else $error("coefficient sweep ended early");

  a_last_stage_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (en && vr) |=> result.valid)
    else $error("result lost between last stage and output register");
`endif

endmodule
`default_nettype wire

// ===== tb/scdc_calibration_checker.sv =====
// checker for the strip charge-division calibrator: predicts and compares every result
`default_nettype none
module scdc_calibration_checker #(
  parameter int DETECTORS     = 16,
  parameter int SIDES         = 2,
  parameter int STRIPS        = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  scdc_hit_if    hit,
  scdc_result_if result,
  scdc_cfg_if    cfg,
  output int     errors,
  output int     pending
);
  import scdc_pkg::*;

  localparam int     CHANNELS = DETECTORS * SIDES * STRIPS;
  localparam longint ONE      = longint'(1) << FRACTION_BITS;
  localparam longint HALF     = longint'(1) << (FRACTION_BITS - 1);

  typedef struct {
    logic [ST_W-1:0] status;
    int              energy;
    int              position;
  } calib_t;

  calib_t expected_q[$];
  int     coef_table[CHANNELS*NCOEF];
  int     lower_gate;
  int     upper_gate;
  bit     pos_corr_on;

  function automatic int clamp(longint v);
    int r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = int'(v);
    return r;
  endfunction

  function automatic int qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + HALF;
    return clamp(p >>> FRACTION_BITS);
  endfunction

  function automatic int qdiv(longint num, longint den);
    int r;
    if (den == 0) r = (num >= 0) ? 32'sh7fffffff : 32'sh80000000;
    else r = clamp((num * ONE) / den);
    return r;
  endfunction

  function automatic void load_identity();
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int k = 0; k < NCOEF; k++) coef_table[ch*NCOEF+k] = 0;
      coef_table[ch*NCOEF+K_C0_SLOPE] = int'(ONE);
      coef_table[ch*NCOEF+K_L_SLOPE]  = int'(ONE);
      coef_table[ch*NCOEF+K_R_SLOPE]  = int'(ONE);
      coef_table[ch*NCOEF+K_P0]       = int'(ONE);
      coef_table[ch*NCOEF+K_C3_SLOPE] = int'(ONE);
    end
  endfunction

  function automatic calib_t calibrate(logic [CMD_W-1:0] cmd, int det, int side, int strip,
                                       int el, int er, bit skip, int ci, int cv);
    calib_t res;
    bit     ok;
    int     base, l, r, sum, pos, scale, en, de, d, lo, hi;
    int     bp[3];
    longint dg;
    ok   = det < DETECTORS && side < SIDES && strip < STRIPS;
    base = ok ? ((det * SIDES + side) * STRIPS + strip) * NCOEF : 0;
    res.status = ST_OK;
    res.energy = 0;
    res.position = 0;
    if (cmd == CMD_WRITE) begin
      if (!ok) res.status = ST_CHANNEL;
      else if (ci < NCOEF) coef_table[base+ci] = cv;
    end else if (cmd == CMD_ENERGY) begin
      if (!ok) begin
        res.status = ST_CHANNEL;
        res.energy = el;
      end else begin
        res.energy = clamp(longint'(qmul(coef_table[base+K_C0_SLOPE], el))
                           + coef_table[base+K_C0_INT]);
      end
    end else if (cmd == CMD_PAIR) begin
      if (!ok) begin
        res.status = ST_CHANNEL;
      end else begin
        l = clamp(longint'(qmul(coef_table[base+K_L_SLOPE], el)) + coef_table[base+K_L_INT]);
        r = clamp(longint'(qmul(coef_table[base+K_R_SLOPE], er)) + coef_table[base+K_R_INT]);
        sum = clamp(longint'(l) + r);
        if (sum <= 0) begin
          res.status = ST_SUM;
        end else begin
          pos = qdiv(longint'(r) - l, sum);
          scale = clamp(longint'(coef_table[base+K_P0]) + qmul(coef_table[base+K_P1], pos)
                        + qmul(qmul(coef_table[base+K_P2], pos), pos));
          if (scale == 0) begin
            res.status = ST_SCALE;
          end else begin
            en = qmul(qdiv(sum, scale), upper_gate);
            en = clamp(longint'(qmul(coef_table[base+K_C3_SLOPE], en))
                       + coef_table[base+K_C3_INT]);
            if (!skip && pos_corr_on) begin
              dg = longint'(upper_gate) - lower_gate;
              de = clamp(longint'(en) - lower_gate);
              for (int k = 0; k < 3; k++) begin
                lo = coef_table[base+K_X01+k];
                hi = coef_table[base+K_X11+k];
                bp[k] = clamp(longint'(qmul(qdiv(longint'(hi) - lo, dg), de)) + lo);
              end
              d = clamp(longint'(pos) - bp[1]);
              // two-sided slope around the middle breakpoint
              if (pos > bp[1]) pos = qmul(qdiv(HALF, longint'(bp[2]) - bp[1]), d);
              else pos = qmul(qdiv(-HALF, longint'(bp[0]) - bp[1]), d);
            end
            res.energy = en;
          end
          res.position = pos;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    calib_t want;
    if (rst) begin
      load_identity();
      lower_gate  = 0;
      upper_gate  = int'(ONE);
      pos_corr_on = 0;
      expected_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LOWER_GATE: lower_gate = cfg.data;
          REG_UPPER_GATE: upper_gate = cfg.data;
          REG_POS_CORR:   pos_corr_on = cfg.data[0];
          default: ;
        endcase
      end
      if (hit.valid && hit.ready) begin
        expected_q.push_back(calibrate(hit.command, hit.detector_index, hit.side_index,
                                       hit.strip_index, hit.energy_left, hit.energy_right,
                                       hit.skip_position, hit.coefficient_index,
                                       hit.coefficient_value));
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected: status %0d", result.status);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            errors <= errors + 1;
          end else if (result.energy_out !== want.energy) begin
            $error("energy_out: expected %0d, actual %0d", want.energy, result.energy_out);
            errors <= errors + 1;
          end else if (result.position_out !== want.position) begin
            $error("position_out: expected %0d, actual %0d", want.position,
                   result.position_out);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_strip_charge_division_calibrator_top.sv =====
// testbench top: stimulus, handshake pacing and verdict for the calibrator
`default_nettype none
module tb_strip_charge_division_calibrator_top;
  import scdc_pkg::*;

  localparam int ONE        = 65536;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 60;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   send_idle;
  int   stall_pct;
  bit   hold_req;
  int   hold_left;
  int   quiet;

  scdc_hit_if    hit_ch ();
  scdc_result_if res_ch ();
  scdc_cfg_if    cfg_ch ();

  strip_charge_division_calibrator_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .hit    (hit_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  scdc_calibration_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .hit     (hit_ch),
    .result  (res_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stalls, plus a long hold-off when asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req  = 0;
      hold_left = 300;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((hit_ch.valid && hit_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
    end
    if (quiet >= IDLE_LIMIT) begin
      $display("tb_strip_charge_division_calibrator_top: errors");
      $finish;
    end
  end

  task automatic hit_send(logic [CMD_W-1:0] cmd, logic [DET_W-1:0] det,
                          logic [SIDE_W-1:0] side, logic [STRIP_W-1:0] strip,
                          logic [VAL_W-1:0] el, logic [VAL_W-1:0] er, logic skip,
                          logic [CIDX_W-1:0] ci, logic [VAL_W-1:0] cv);
    while ($urandom_range(99) < send_idle) begin
      hit_ch.valid <= 1'b0;
      @(negedge clk);
    end
    hit_ch.command           <= cmd;
    hit_ch.detector_index    <= det;
    hit_ch.side_index        <= side;
    hit_ch.strip_index       <= strip;
    hit_ch.energy_left       <= el;
    hit_ch.energy_right      <= er;
    hit_ch.skip_position     <= skip;
    hit_ch.coefficient_index <= ci;
    hit_ch.coefficient_value <= cv;
    hit_ch.valid             <= 1'b1;
    @(posedge clk);
    while (!hit_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    hit_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic reg_write(logic [CFG_W-1:0] idx, logic [VAL_W-1:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_gates(int lower, int upper, bit pc);
    drain();
    repeat (DRAIN_WAIT) @(negedge clk);
    reg_write(REG_LOWER_GATE, lower);
    reg_write(REG_UPPER_GATE, upper);
    reg_write(REG_POS_CORR, {31'($urandom), pc});
  endtask

  function automatic int coef_pick(int ci);
    int v;
    if ($urandom_range(7) == 0) return int'($urandom);
    case (ci)
      K_C0_SLOPE, K_L_SLOPE, K_R_SLOPE, K_C3_SLOPE, K_P0:
        v = ONE + int'($urandom_range(0, ONE / 2)) - ONE / 4;
      K_P1, K_P2:
        v = int'($urandom_range(0, ONE / 2)) - ONE / 4;
      K_C0_INT, K_L_INT, K_R_INT, K_C3_INT:
        v = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
      default:
        v = int'($urandom_range(0, ONE)) - ONE / 2;
    endcase
    return v;
  endfunction

  task automatic random_hit();
    logic [DET_W-1:0]   det;
    logic [SIDE_W-1:0]  side;
    logic [STRIP_W-1:0] strip;
    logic [CMD_W-1:0]   cmd;
    logic [CIDX_W-1:0]  ci;
    int                 c;
    int                 el;
    int                 er;
    if ($urandom_range(9) == 0) begin
      det   = DET_W'($urandom);
      side  = SIDE_W'($urandom);
      strip = STRIP_W'($urandom);
    end else begin
      det   = DET_W'($urandom_range(0, 1));
      side  = SIDE_W'($urandom_range(0, 1));
      strip = STRIP_W'($urandom_range(0, 7));
    end
    c = $urandom_range(99);
    if (c < 25) cmd = CMD_WRITE;
    else if (c < 45) cmd = CMD_ENERGY;
    else if (c < 95) cmd = CMD_PAIR;
    else cmd = CMD_NONE;
    ci = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(0, NCOEF - 1));
    el = ($urandom_range(7) == 0) ? int'($urandom) : int'($urandom_range(0, 100 * ONE));
    er = ($urandom_range(7) == 0) ? int'($urandom) : int'($urandom_range(0, 100 * ONE));
    hit_send(cmd, det, side, strip, el, er, $urandom_range(3) == 0, ci, coef_pick(ci));
  endtask

  initial begin
    rst = 1'b1;
    hit_ch.valid = 1'b0;
    hit_ch.command = CMD_NONE;
    hit_ch.detector_index = '0;
    hit_ch.side_index = '0;
    hit_ch.strip_index = '0;
    hit_ch.energy_left = '0;
    hit_ch.energy_right = '0;
    hit_ch.skip_position = 1'b0;
    hit_ch.coefficient_index = '0;
    hit_ch.coefficient_value = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LOWER_GATE;
    cfg_ch.data = '0;
    send_idle = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    quiet = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners on the reset calibration
    hit_send(CMD_ENERGY, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 0);
    hit_send(CMD_ENERGY, 0, 0, 0, 32'h80000000, 0, 0, 0, 0);
    hit_send(CMD_ENERGY, 16, 0, 0, 123, 0, 0, 0, 0);
    hit_send(CMD_ENERGY, 255, 3, 63, 32'hffffffff, 32'hffffffff, 1, 31, 32'hffffffff);
    hit_send(CMD_PAIR, 0, 0, 0, ONE, 3 * ONE, 0, 0, 0);
    hit_send(CMD_PAIR, 0, 0, 0, -ONE, 0, 0, 0, 0);
    hit_send(CMD_PAIR, 0, 2, 0, ONE, ONE, 0, 0, 0);
    hit_send(CMD_PAIR, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    hit_send(CMD_WRITE, 0, 0, 8, 0, 0, 0, K_P0, 0);
    hit_send(CMD_WRITE, 0, 0, 0, 0, 0, 0, 31, 0);
    hit_send(CMD_NONE, 1, 1, 1, ONE, ONE, 1, 1, ONE);
    // zero scale on equal ends
    hit_send(CMD_WRITE, 0, 0, 1, 0, 0, 0, K_P0, 0);
    hit_send(CMD_PAIR, 0, 0, 1, ONE, ONE, 0, 0, 0);
    hit_send(CMD_WRITE, 0, 0, 2, 0, 0, 0, K_L_SLOPE, 32'h7fffffff);
    hit_send(CMD_PAIR, 0, 0, 2, 32'h7fffffff, ONE, 0, 0, 0);
    hit_send(CMD_WRITE, 0, 0, 2, 0, 0, 0, K_C0_INT, 32'h80000000);
    hit_send(CMD_ENERGY, 0, 0, 2, 32'h80000000, 0, 0, 0, 0);
    // equal breakpoints and equal gates
    set_gates(5 * ONE, 5 * ONE, 1);
    hit_send(CMD_PAIR, 0, 1, 0, ONE, 2 * ONE, 0, 0, 0);
    hit_send(CMD_PAIR, 0, 1, 0, 2 * ONE, ONE, 0, 0, 0);
    hit_send(CMD_PAIR, 0, 1, 0, 2 * ONE, ONE, 1, 0, 0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_gates(0, 10 * ONE, 1);
        1: set_gates(32'h80000000, 32'h7fffffff, 1);
        2: set_gates(-ONE, 3 * ONE, 0);
        3: set_gates(ONE, 50 * ONE, 1);
        default: set_gates(32'h7fffffff, 32'h80000000, 1);
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 58; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 58; end
        default: begin send_idle = 27; stall_pct = 27; end
      endcase
      for (int n = 0; n < 100; n++) begin
        if (ph == 1 && n == 50) hold_req = 1;
        if (ph == 2 && n == 50) drain();
        random_hit();
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("tb_strip_charge_division_calibrator_top: clean");
    end else begin
      $display("tb_strip_charge_division_calibrator_top: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
